@@ rtl/aes_pkg.sv @@
package aes_pkg;

    typedef struct packed {
        logic       mode;
        logic [3:0] round_index;
        logic [3:0] key_byte_index;
        logic [7:0] data_byte;
        logic       stream_last;
    } aes_in_t;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       out_stream_last;
        logic       block_end;
    } aes_out_t;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    localparam logic [1:0] KLS_128 = 2'd0;
    localparam logic [1:0] KLS_192 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_EMIT
    } aes_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       key_wr;
        logic       data_wr;
        logic       key_rd;
        logic [3:0] key_rd_round;
        logic [3:0] key_rd_byte;      // state byte folded with key 0 in ST_LOAD
        logic       state_load_byte;
        logic       do_round;
        logic       final_round;
        logic       emit;
        logic [3:0] emit_idx;
    } aes_cmd_t;

    typedef logic [7:0] sbox_arr_t [256];

    localparam sbox_arr_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

@@ rtl/aes_ecb_block_encrypt.sv @@
// AES-ECB encryption with pre-expanded round keys.
//
// Input channel: a transaction is taken on a rising edge with start high and
// busy low. mode 0 writes one byte of a round key; it never raises busy.
// mode 1 pushes a plaintext byte; the sixteenth one starts the cipher.
//
// Cipher run: the load state folds round key 0 into the state one byte per
// cycle (the plaintext buffer has one read port), then one full round per
// cycle from the round-key memory row read, Nr rounds (10/12/14). Then the
// emit state steps through the state; each ciphertext byte shows on result
// for one cycle with result_valid high, in the cycle after its step;
// block_end marks byte 15. busy falls once the last byte is stepped, so the
// next transaction can be taken while the last byte is on the result ports.
// The receiver cannot stall: each result is valid for exactly one cycle.
//
// key_length_select is sampled when the sixteenth byte is accepted; write it
// only while idle. Reset clears the control and the byte count; round keys
// and plaintext are undefined until written.
module aes_ecb_block_encrypt
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  aes_in_t    in_item,
    output logic       result_valid,
    output aes_out_t   result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);
    logic [1:0] kls_reg;
    aes_cmd_t   cmd;

    // hold the key length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kls_reg <= KLS_128;
        else if (cfg_we)
            kls_reg <= cfg_wdata;
    end

    aes_ctrl #(.MAX_ROUND_KEYS(MAX_ROUND_KEYS)) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .in_item           (in_item),
        .key_length_select (kls_reg),
        .busy              (busy),
        .cmd               (cmd)
    );

    aes_datapath #(.MAX_ROUND_KEYS(MAX_ROUND_KEYS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule

@@ rtl/aes_ctrl.sv @@
module aes_ctrl
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  aes_in_t    in_item,
    input  logic [1:0] key_length_select,
    output logic       busy,
    output aes_cmd_t   cmd
);
    localparam logic [3:0] NR_CAP = 4'(MAX_ROUND_KEYS - 1);

    aes_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;      // load byte / round / emit index
    logic [3:0] nr_reg, nr_next;
    logic [3:0] fill_reg, fill_next;    // plaintext bytes held
    logic [3:0] nr_sel;
    logic       acc;

    assign busy = (state_reg != ST_IDLE);
    assign acc  = start && !busy;

    always_comb
    begin
        case (key_length_select)
            KLS_128: nr_sel = 4'd10;
            KLS_192: nr_sel = 4'd12;
            default: nr_sel = 4'd14;
        endcase
        if (nr_sel > NR_CAP)
            nr_sel = NR_CAP;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        nr_next    = nr_reg;
        fill_next  = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && in_item.mode == MODE_DATA)
                begin
                    fill_next = fill_reg + 4'd1;
                    if (fill_reg == 4'd15)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = 4'd0;
                        nr_next    = nr_sel;
                    end
                end
            end
            ST_LOAD:
            begin
                // byte k of plaintext meets key 0 byte k
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_ROUND;
                    cnt_next   = 4'd1;
                end
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == nr_reg)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = 4'd0;
                end
            end
            ST_EMIT:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.key_wr  = acc && in_item.mode == MODE_KEY;
        cmd.data_wr = acc && in_item.mode == MODE_DATA;
        // fetch the key row that the next state works with
        case (state_next)
            ST_LOAD:
            begin
                cmd.key_rd       = 1'b1;
                cmd.key_rd_round = 4'd0;
            end
            ST_ROUND:
            begin
                cmd.key_rd       = 1'b1;
                cmd.key_rd_round = cnt_next;
            end
            default: ;
        endcase
        case (state_reg)
            ST_LOAD:
            begin
                cmd.state_load_byte = 1'b1;
                cmd.key_rd_byte     = cnt_reg;
            end
            ST_ROUND:
            begin
                cmd.do_round    = 1'b1;
                cmd.final_round = (cnt_reg == nr_reg);
            end
            ST_EMIT:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_idx = cnt_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            nr_reg    <= 4'd10;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nr_reg    <= nr_next;
            fill_reg  <= fill_next;
        end
    end
endmodule

@@ rtl/aes_datapath.sv @@
module aes_datapath
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = 15
) (
    input  logic     clk,
    input  logic     rst_n,
    input  aes_in_t  in_item,
    input  aes_cmd_t cmd,
    output logic     result_valid,
    output aes_out_t result
);
    localparam int RK_W = $clog2(MAX_ROUND_KEYS);

    // round keys: one 128-bit row per round, byte-writable
    logic [127:0] rk_mem [MAX_ROUND_KEYS];
    logic [127:0] rk_rd_reg;
    logic [7:0]   plain_mem [16];
    logic [15:0]  last_reg;
    logic [3:0]   wr_ptr_reg;
    logic [7:0]   st_reg [16];
    logic [7:0]   sb [16];
    logic [7:0]   mx [16];
    logic         result_valid_reg;
    aes_out_t     result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.key_wr && in_item.round_index < 4'(MAX_ROUND_KEYS))
            rk_mem[in_item.round_index[RK_W-1:0]][in_item.key_byte_index*8 +: 8]
                <= in_item.data_byte;
        if (cmd.key_rd)
            rk_rd_reg <= rk_mem[cmd.key_rd_round[RK_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_ptr_reg <= '0;
        else if (cmd.data_wr)
            wr_ptr_reg <= wr_ptr_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_wr)
        begin
            plain_mem[wr_ptr_reg]  <= in_item.data_byte;
            last_reg[wr_ptr_reg]   <= in_item.stream_last;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sb[r + 4*c] = SBOX[st_reg[r + 4*((c + r) % 4)]];
        for (int c = 0; c < 16; c += 4)
        begin
            logic [7:0] all;
            all = sb[c] ^ sb[c+1] ^ sb[c+2] ^ sb[c+3];
            mx[c]   = sb[c]   ^ all ^ xtime(sb[c]   ^ sb[c+1]);
            mx[c+1] = sb[c+1] ^ all ^ xtime(sb[c+1] ^ sb[c+2]);
            mx[c+2] = sb[c+2] ^ all ^ xtime(sb[c+2] ^ sb[c+3]);
            mx[c+3] = sb[c+3] ^ all ^ xtime(sb[c+3] ^ sb[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.state_load_byte)
            st_reg[cmd.key_rd_byte] <= plain_mem[cmd.key_rd_byte]
                ^ rk_rd_reg[cmd.key_rd_byte*8 +: 8];
        else if (cmd.do_round)
            for (int i = 0; i < 16; i++)
                st_reg[i] <= (cmd.final_round ? sb[i] : mx[i]) ^ rk_rd_reg[i*8 +: 8];
        if (cmd.emit)
        begin
            result_reg.cipher_byte     <= st_reg[cmd.emit_idx];
            result_reg.out_stream_last <= last_reg[cmd.emit_idx];
            result_reg.block_end       <= (cmd.emit_idx == 4'd15);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= cmd.emit;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
endmodule

@@ rtl/aes_checker.sv @@
module aes_checker
    import aes_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     busy,
    input logic     result_valid,
    input aes_out_t result
);
    a_end_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.block_end |=> !result_valid)
        else $error("result after block end");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy || result.block_end)
        else $error("result while idle");
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.block_end |-> !busy)
        else $error("busy after last byte");
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.block_end |=> result_valid)
        else $error("gap in result burst");
endmodule

bind aes_ecb_block_encrypt aes_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

@@ dv/aes_ecb_block_encrypt_tb.sv @@
module aes_ecb_block_encrypt_tb
    import aes_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ROUND_KEYS = 15;
    localparam int CIPHER_DRAIN = 80;

    // Cipher model with its own copy of the key store, the partial block and
    // the key length. Expected ciphertext bytes queue up in block order.
    class cipher_scoreboard;
        logic [7:0] key_mem [NUM_ROUND_KEYS*16];
        logic [7:0] pt_bytes [16];
        logic       pt_last [16];
        logic [3:0] fill_cnt;
        logic [1:0] key_len;
        aes_out_t   pending_bytes [$];
        int         errors;

        function new();
            fill_cnt = '0;
            key_len  = KLS_128;
            errors   = 0;
            foreach (key_mem[i]) key_mem[i] = '0;
        endfunction

        function automatic logic [7:0] dbl(logic [7:0] x);
            return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        endfunction

        function automatic void encrypt_block();
            logic [7:0] st [16];
            logic [7:0] tmp [16];
            logic [7:0] a0, a1, a2, a3, all;
            int         rounds;
            aes_out_t   o;
            rounds = (key_len == KLS_128) ? 10 : (key_len == KLS_192) ? 12 : 14;
            if (rounds > NUM_ROUND_KEYS - 1) rounds = NUM_ROUND_KEYS - 1;
            for (int i = 0; i < 16; i++) st[i] = pt_bytes[i] ^ key_mem[i];
            for (int r = 1; r <= rounds; r++)
            begin
                // SubBytes and ShiftRows together: row w rotates left by w
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        tmp[w + 4*c] = SBOX[st[w + 4*((c + w) % 4)]];
                st = tmp;
                if (r < rounds)
                begin
                    for (int c = 0; c < 16; c += 4)
                    begin
                        a0 = st[c]; a1 = st[c+1]; a2 = st[c+2]; a3 = st[c+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        st[c]   = a0 ^ all ^ dbl(a0 ^ a1);
                        st[c+1] = a1 ^ all ^ dbl(a1 ^ a2);
                        st[c+2] = a2 ^ all ^ dbl(a2 ^ a3);
                        st[c+3] = a3 ^ all ^ dbl(a3 ^ a0);
                    end
                end
                for (int i = 0; i < 16; i++) st[i] ^= key_mem[r*16 + i];
            end
            for (int k = 0; k < 16; k++)
            begin
                o.cipher_byte     = st[k];
                o.out_stream_last = pt_last[k];
                o.block_end       = (k == 15);
                pending_bytes.push_back(o);
            end
        endfunction

        // Note one accepted input transaction.
        function automatic void note_input(aes_in_t t);
            if (t.mode == MODE_KEY)
            begin
                if (t.round_index < NUM_ROUND_KEYS)
                    key_mem[t.round_index*16 + t.key_byte_index] = t.data_byte;
                return;
            end
            pt_bytes[fill_cnt] = t.data_byte;
            pt_last[fill_cnt]  = t.stream_last;
            fill_cnt++;
            if (fill_cnt == 0) encrypt_block();
        endfunction

        function automatic void check_result(aes_out_t got);
            aes_out_t want;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected result byte %h", got.cipher_byte);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.cipher_byte !== want.cipher_byte)
            begin
                $error("cipher_byte: expected %h, got %h",
                       want.cipher_byte, got.cipher_byte);
                errors++;
            end
            if (got.out_stream_last !== want.out_stream_last)
            begin
                $error("out_stream_last: expected %b, got %b",
                       want.out_stream_last, got.out_stream_last);
                errors++;
            end
            if (got.block_end !== want.block_end)
            begin
                $error("block_end: expected %b, got %b",
                       want.block_end, got.block_end);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    aes_in_t    in_item;
    logic       result_valid;
    aes_out_t   result;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    cipher_scoreboard sb;
    int idle_pct;   // chance in percent that the sender idles a cycle

    aes_ecb_block_encrypt #(.MAX_ROUND_KEYS(NUM_ROUND_KEYS)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .in_item     (in_item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Results cannot be held off: check every strobe as it comes.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1) sb.check_result(result);
    end

    // Drive one transaction: idle at random first, then hold start until the
    // block takes it. start stays high for the next call; drain drops it.
    task automatic send(aes_in_t t);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= t;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        sb.note_input(t);
    endtask

    task automatic send_key(int r, int b, logic [7:0] v);
        aes_in_t t;
        t = '0;
        t.mode           = MODE_KEY;
        t.round_index    = 4'(r);
        t.key_byte_index = 4'(b);
        t.data_byte      = v;
        t.stream_last    = 1'($urandom_range(1));
        send(t);
    endtask

    task automatic send_data(logic [7:0] v, logic last);
        aes_in_t t;
        t.mode           = MODE_DATA;
        t.round_index    = 4'($urandom_range(15));
        t.key_byte_index = 4'($urandom_range(15));
        t.data_byte      = v;
        t.stream_last    = last;
        send(t);
    endtask

    // Drop start, wait for every expected byte, then let the block fall idle.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge clk);
        repeat (CIPHER_DRAIN) @(posedge clk);
    endtask

    // Write the key length only while the block is quiet.
    task automatic set_key_len(logic [1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.key_len = v;
    endtask

    // Load every byte of every round key so no read is undefined.
    task automatic load_all_keys(bit rand_vals);
        for (int r = 0; r < NUM_ROUND_KEYS; r++)
            for (int b = 0; b < 16; b++)
                send_key(r, b, rand_vals ? 8'($urandom) : 8'(r*16 + b));
    endtask

    // One well-formed block with random content, with random key traffic
    // mixed in.
    task automatic random_block();
        for (int i = 0; i < 16; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                // includes the out-of-range round index, which must be dropped
                send_key($urandom_range(15), $urandom_range(15), 8'($urandom));
            end
            send_data(8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        idle_pct  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: known keys, then blocks of all-zero, all-one and stepped bytes.
        load_all_keys(1'b0);
        send_key(15, 0, 8'hff);  // out of range, must leave the store alone
        send_key(15, 15, 8'h00);
        for (int i = 0; i < 16; i++) send_data(8'h00, 1'b0);
        for (int i = 0; i < 16; i++) send_data(8'hff, 1'b1);
        for (int i = 0; i < 16; i++) send_data(8'(i * 17), i[0]);

        // Random phases, one key length each with the unused code 3 last:
        // sender idles 28%, then 79%, then not at all.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 79 : 0;
            set_key_len(2'(ph + 1));
            for (int i = 0; i < 4; i++) send_key(i, $urandom_range(15), 8'($urandom));
            random_block();
            // a partial block stays held across the config write
            if (ph == 0) for (int i = 0; i < 5; i++) send_data(8'($urandom), 1'b1);
            if (ph == 1) for (int i = 0; i < 11; i++) send_data(8'($urandom), 1'b0);
        end

        drain();
        if (sb.errors == 0 && sb.pending_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/aes_pkg.sv
rtl/aes_ctrl.sv
rtl/aes_datapath.sv
rtl/aes_ecb_block_encrypt.sv
rtl/aes_checker.sv
dv/aes_ecb_block_encrypt_tb.sv
